// ===== hw/rtl/assert_macros.svh =====
// assertion macros included by the generator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle, checked out of reset
`define XSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define XSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/xsr_pkg.sv =====
// types and constants for the xoshiro128** generator
`timescale 1ns / 1ps
`default_nettype none

package xsr_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned NWords = 4;
  localparam int unsigned StepW  = 7;

  typedef logic [NWords-1:0][WordW-1:0] gen_words_t;

  typedef enum logic [1:0] {
    KIND_NEXT      = 2'd0,
    KIND_SEED      = 2'd1,
    KIND_JUMP      = 2'd2,
    KIND_LONG_JUMP = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_JUMP,
    ST_DONE
  } state_e;

  // state after seeding with one and a single advance
  localparam gen_words_t ResetWords = {32'h0000_0800, 32'h0000_0200,
                                       32'h0000_0001, 32'h0000_0001};

  // bit n of the polynomial is tested at jump step n
  localparam logic [127:0] JumpPoly = {32'h77f2_db5b, 32'h6fa0_35c3,
                                       32'hf542_d2d3, 32'h8764_000b};
  localparam logic [127:0] LongJumpPoly = {32'h1c58_0662, 32'hccf5_a0ef,
                                           32'h0b6f_099f, 32'hb523_952e};

  localparam int unsigned ScrRot   = 7;
  localparam int unsigned StateShl = 9;
  localparam int unsigned StateRot = 11;

endpackage

`default_nettype wire

// ===== hw/rtl/xoshiro128_starstar_generator.sv =====
// xoshiro128** pseudo-random generator with seed, jump and long jump
//
// input channel carries kind_i and seed_value_i; one word comes back on the
// output channel for every input word. kind next returns the scrambled word
// rotl(s1*5,7)*9 and advances the 128-bit state; seed loads s1 and advances
// once; jump and long jump move the state on by 2^64 and 2^96 steps. every
// kind other than next returns zero.
// next and seed pass through the shared advance unit in the step state, then
// the done state fills the output register. jump kinds use the same advance
// unit once per polynomial bit, 128 passes, in the jump state before the done
// state. one word is worked on at a time; a new word is taken once the
// previous result sits in the output register.
// reset puts the state as after seeding with one and leaves no result
// pending. while the receiver stalls the result holds in the output
// register; a following word may be taken and worked on but waits in the
// done state until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module xoshiro128_starstar_generator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] seed_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      value_o
);

  `include "assert_macros.svh"

  xsr_pkg::state_e     state_q, state_d;
  xsr_pkg::kind_e      kind_q, kind_d;
  xsr_pkg::gen_words_t words_q, words_d;
  xsr_pkg::gen_words_t accum_q, accum_d;
  logic [xsr_pkg::StepW-1:0] step_q, step_d;
  logic [xsr_pkg::WordW-1:0] prod_q, prod_d;
  logic [xsr_pkg::WordW-1:0] res_q, res_d;
  logic [xsr_pkg::WordW-1:0] value_q, value_d;
  logic                      out_valid_q, out_valid_d;

  // shared advance unit
  xsr_pkg::gen_words_t adv;
  logic [xsr_pkg::WordW-1:0] t_shl, w2_x, w3_x;
  logic [xsr_pkg::WordW-1:0] rot_p;
  logic [127:0]              poly;
  logic                      poly_bit;
  logic                      accept, out_free;

  always_comb begin
    t_shl  = words_q[1] << xsr_pkg::StateShl;
    w2_x   = words_q[2] ^ words_q[0];
    w3_x   = words_q[3] ^ words_q[1];
    adv[0] = words_q[0] ^ w3_x;
    adv[1] = words_q[1] ^ w2_x;
    adv[2] = w2_x ^ t_shl;
    adv[3] = {w3_x[xsr_pkg::WordW-xsr_pkg::StateRot-1:0],
              w3_x[xsr_pkg::WordW-1:xsr_pkg::WordW-xsr_pkg::StateRot]};
  end

  assign rot_p = {prod_q[xsr_pkg::WordW-xsr_pkg::ScrRot-1:0],
                  prod_q[xsr_pkg::WordW-1:xsr_pkg::WordW-xsr_pkg::ScrRot]};

  assign poly     = (kind_q == xsr_pkg::KIND_LONG_JUMP) ? xsr_pkg::LongJumpPoly
                                                        : xsr_pkg::JumpPoly;
  assign poly_bit = poly[step_q];

  assign in_ready_o = (state_q == xsr_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      xsr_pkg::ST_IDLE: begin
        if (accept) begin
          if (kind_i inside {xsr_pkg::KIND_NEXT, xsr_pkg::KIND_SEED}) begin
            state_d = xsr_pkg::ST_STEP;
          end else begin
            state_d = xsr_pkg::ST_JUMP;
          end
        end
      end
      xsr_pkg::ST_STEP: state_d = xsr_pkg::ST_DONE;
      xsr_pkg::ST_JUMP: begin
        if (step_q == {xsr_pkg::StepW{1'b1}}) begin
          state_d = xsr_pkg::ST_DONE;
        end
      end
      xsr_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = xsr_pkg::ST_IDLE;
        end
      end
      default: state_d = xsr_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    kind_d      = kind_q;
    words_d     = words_q;
    accum_d     = accum_q;
    step_d      = step_q;
    prod_d      = prod_q;
    res_d       = res_q;
    value_d     = value_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      xsr_pkg::ST_IDLE: begin
        if (accept) begin
          kind_d = xsr_pkg::kind_e'(kind_i);
          // s1 * 5 as shift and add
          prod_d = (words_q[1] << 2) + words_q[1];
          res_d  = '0;
          if (kind_i == xsr_pkg::KIND_SEED) begin
            words_d = {32'd0, 32'd0, seed_value_i, 32'd0};
          end else if (kind_i != xsr_pkg::KIND_NEXT) begin
            accum_d = '0;
            step_d  = '0;
          end
        end
      end
      xsr_pkg::ST_STEP: begin
        words_d = adv;
        if (kind_q == xsr_pkg::KIND_NEXT) begin
          res_d = (rot_p << 3) + rot_p;
        end else begin
          res_d = '0;
        end
      end
      xsr_pkg::ST_JUMP: begin
        if (poly_bit) begin
          accum_d = accum_q ^ words_q;
        end
        step_d = step_q + 1'b1;
        // last step: the accumulator becomes the new state
        if (step_q == {xsr_pkg::StepW{1'b1}}) begin
          words_d = accum_d;
        end else begin
          words_d = adv;
        end
      end
      xsr_pkg::ST_DONE: begin
        if (out_free) begin
          value_d     = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xsr_pkg::ST_IDLE;
      kind_q      <= xsr_pkg::KIND_NEXT;
      words_q     <= xsr_pkg::ResetWords;
      accum_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      words_q     <= words_d;
      accum_q     <= accum_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    res_q   <= res_d;
    value_q <= value_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  `XSR_ASSERT(a_step_idle_zero, (state_q != xsr_pkg::ST_JUMP) |-> (step_q == '0), "jump step counter not back at zero outside a jump")
  `XSR_ASSERT(a_nonnext_zero, (state_q == xsr_pkg::ST_DONE && kind_q != xsr_pkg::KIND_NEXT) |-> (res_q == '0), "non-next word produced a nonzero result")
  `XSR_ASSERT_NEXT(a_accept_starts, accept, (state_q == xsr_pkg::ST_STEP || state_q == xsr_pkg::ST_JUMP), "accepted word did not start work")

endmodule

`default_nettype wire

// ===== tb/xsr_checker.sv =====
// checker for the xoshiro128** generator: predicts every result word and compares
`timescale 1ns / 1ps

module xsr_checker
  import xsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] seed_value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] value_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  gen_words_t  gen_state;
  logic [31:0] pending_values[$];
  kind_e       pending_kinds[$];

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned k);
    return (x << k) | (x >> (WordW - k));
  endfunction

  function automatic logic [31:0] scramble_word(input gen_words_t w);
    logic [31:0] m;
    m = w[1] * 32'd5;
    return rotl32(m, ScrRot) * 32'd9;
  endfunction

  function automatic gen_words_t advance_words(input gen_words_t w);
    gen_words_t  n;
    logic [31:0] t;
    n = w;
    t = w[1] << StateShl;
    n[2] = n[2] ^ n[0];
    n[3] = n[3] ^ n[1];
    n[1] = n[1] ^ n[2];
    n[0] = n[0] ^ n[3];
    n[2] = n[2] ^ t;
    n[3] = rotl32(n[3], StateRot);
    return n;
  endfunction

  function automatic gen_words_t seed_words(input logic [31:0] s);
    gen_words_t n;
    n = '0;
    n[1] = s;
    return advance_words(n);
  endfunction

  // xor the state into the sum at every set polynomial bit, 128 advances
  function automatic gen_words_t jump_words(input gen_words_t w, input logic [127:0] poly);
    gen_words_t acc;
    gen_words_t cur;
    acc = '0;
    cur = w;
    for (int i = 0; i < 128; i++) begin
      if (poly[i]) begin
        acc = acc ^ cur;
      end
      cur = advance_words(cur);
    end
    return acc;
  endfunction

  task automatic report(input string what);
    $display("%0t mismatch: %0s", $realtime, what);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    kind_e       k;
    if (!rst_ni) begin
      gen_state = seed_words(32'd1);
      pending_values.delete();
      pending_kinds.delete();
    end else begin
      // result side first: a word taken at this edge cannot already be answered
      if (out_valid_i && out_ready_i) begin
        if (pending_values.size() == 0) begin
          report($sformatf("result %08h with no word pending", value_i));
        end else begin
          want = pending_values.pop_front();
          k    = pending_kinds.pop_front();
          checked_o++;
          if (value_i !== want) begin
            report($sformatf("%0s word: value %08h, predicted %08h", k.name(), value_i, want));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        k    = kind_e'(kind_i);
        want = '0;
        case (k)
          KIND_NEXT: begin
            want      = scramble_word(gen_state);
            gen_state = advance_words(gen_state);
          end
          KIND_SEED: gen_state = seed_words(seed_value_i);
          KIND_JUMP: gen_state = jump_words(gen_state, JumpPoly);
          default:   gen_state = jump_words(gen_state, LongJumpPoly);
        endcase
        pending_values.push_back(want);
        pending_kinds.push_back(k);
      end
    end
    pending_o = pending_values.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// top of the xoshiro128** generator testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import xsr_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int HoldCycles  = 300;
  localparam int TailCycles  = 200;
  localparam int RandomWords = 750;
  localparam int CalmFirst   = 450;
  localparam int CalmLast    = 550;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [31:0] seed_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] value_o;

  int fail_count;
  int pending;
  int checked;
  int n_sent;
  int zero_seeds;
  int kind_count[4];
  bit hold_done;

  xoshiro128_starstar_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .seed_value_i (seed_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o)
  );

  xsr_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .kind_i       (kind_i),
    .seed_value_i (seed_value_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_i      (value_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit calm_stretch();
    return n_sent >= CalmFirst && n_sent < CalmLast;
  endfunction

  // called at a falling edge; returns at a falling edge after the word is taken
  task automatic send_word(input kind_e k, input logic [31:0] s);
    in_valid_i   <= 1'b1;
    kind_i       <= k;
    seed_value_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_sent++;
    kind_count[k]++;
    if (k == KIND_SEED && s == '0) begin
      zero_seeds++;
    end
    @(negedge clk_i);
    if (!calm_stretch() && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
  endtask

  task automatic send_random_word();
    int          r;
    kind_e       k;
    logic [31:0] s;
    r = $urandom_range(99);
    if (r < 80) k = KIND_NEXT;
    else if (r < 90) k = KIND_SEED;
    else if (r < 95) k = KIND_JUMP;
    else k = KIND_LONG_JUMP;
    r = $urandom_range(99);
    if (r < 3) s = '0;
    else if (r < 5) s = '1;
    else s = $urandom;
    send_word(k, s);
  endtask

  // receiver: random stalls, one long hold-off so the block backs up its input
  initial begin
    out_ready_i = 1'b0;
    hold_done   = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && n_sent >= 200) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (calm_stretch()) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 36);
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= IdleLimit) begin
        $display("watchdog: no handshake for %0d cycles, %0d words pending", idle, pending);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    kind_i       = KIND_NEXT;
    seed_value_i = '0;
    n_sent       = 0;
    zero_seeds   = 0;
    foreach (kind_count[i]) kind_count[i] = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // from the reset state; seed word is ignored outside seed
    send_word(KIND_NEXT, 32'hffff_ffff);
    send_word(KIND_NEXT, 32'h0000_0000);
    send_word(KIND_NEXT, 32'h5a5a_5a5a);
    // zero seed sticks at the all-zero state, through a jump too
    send_word(KIND_SEED, 32'h0000_0000);
    send_word(KIND_NEXT, 32'h1234_5678);
    send_word(KIND_NEXT, 32'h0000_0000);
    send_word(KIND_JUMP, 32'hffff_ffff);
    send_word(KIND_NEXT, 32'h0000_0000);
    send_word(KIND_LONG_JUMP, 32'h0000_0000);
    send_word(KIND_NEXT, 32'h0000_0000);
    // extreme seeds
    send_word(KIND_SEED, 32'hffff_ffff);
    send_word(KIND_NEXT, 32'h0000_0000);
    send_word(KIND_NEXT, 32'hffff_ffff);
    send_word(KIND_SEED, 32'h8000_0000);
    send_word(KIND_NEXT, 32'h0000_0000);
    send_word(KIND_SEED, 32'h0000_0001);
    send_word(KIND_NEXT, 32'h0000_0000);
    // both jumps back to back, then a jump again with nexts before and after
    send_word(KIND_JUMP, 32'ha5a5_a5a5);
    send_word(KIND_LONG_JUMP, 32'h5a5a_5a5a);
    send_word(KIND_NEXT, 32'h0000_0000);
    send_word(KIND_JUMP, 32'h0000_0000);
    send_word(KIND_NEXT, 32'h0000_0000);
    send_word(KIND_NEXT, 32'h0000_0000);

    repeat (RandomWords) send_random_word();
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    $display("covered %0d words: %0d next, %0d seed (%0d zero), %0d jump, %0d long jump",
             n_sent, kind_count[KIND_NEXT], kind_count[KIND_SEED], zero_seeds,
             kind_count[KIND_JUMP], kind_count[KIND_LONG_JUMP]);
    $display("%0d results compared, %0d mismatches, one output hold-off of %0d cycles",
             checked, fail_count, HoldCycles);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/xsr_pkg.sv
hw/rtl/xoshiro128_starstar_generator.sv
tb/xsr_checker.sv
tb/tb_top.sv
